[hw/rtl/nsr_pkg.sv]
// Shared types and constants of the Newton square root block.
`timescale 1ns / 1ps

package nsr_pkg;

   // Fixed field widths of the item channels and the register port.
   localparam int VALUE_W     = 32;
   localparam int ITER_W      = 7;
   localparam int TOL_W       = 16;
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 40;
   localparam int RSP_PAD_W   = RSP_TDATA_W - VALUE_W - ITER_W;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;

   // Default values for the top-level parameters.
   localparam int DEFAULT_MAX_ITER      = 32;
   localparam int DEFAULT_FRACTION_BITS = 16;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_TOLERANCE   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHECK_FIRST = 1'b1;

   // Register values after reset.
   localparam logic [TOL_W-1:0] TOLERANCE_RESET   = 16'd1;
   localparam logic             CHECK_FIRST_RESET = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_DIV,
      ST_UPDATE,
      ST_SQUARE,
      ST_RESID,
      ST_CHECK,
      ST_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic div_start;
      logic div_step;
      logic update;
      logic square;
      logic resid;
      logic set_nc;
      logic out_load;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic value_zero;
      logic check_first;
      logic converged;
      logic at_cap;
      logic div_last;
   } dp_status_type;

endpackage

[hw/rtl/newton_square_root.sv]
// Top level of the Newton square root block: controller plus datapath.
`timescale 1ns / 1ps
// A zero value goes straight from the start state to the result; otherwise
// updates, counted in the rsp iterations field, each run the divider and then the
// update, square, residual and test states; check_first set puts a test first.
// Each update is dominated by the bit-serial divider, one quotient bit a cycle.
// One item at a time; the next is taken the cycle after the result is loaded.
// Reset (synchronous) idles the controller, drops rsp_tvalid, tolerance=1, check_first=1.

module newton_square_root #(
   parameter int MAX_ITER      = nsr_pkg::DEFAULT_MAX_ITER,
   parameter int FRACTION_BITS = nsr_pkg::DEFAULT_FRACTION_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   // Input item channel.
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [nsr_pkg::REQ_TDATA_W-1:0] req_tdata,   // value[31:0]
   // Result item channel.
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [nsr_pkg::RSP_TDATA_W-1:0] rsp_tdata,   // root[31:0], iterations[38:32], zero pad
   output logic                            rsp_tuser,   // not_converged
   // Register write port.
   input  logic                            csr_we,
   input  logic [nsr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [nsr_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import nsr_pkg::*;

   dp_cmd_type         cmd;
   dp_status_type      status;
   logic [VALUE_W-1:0] root;
   logic [ITER_W-1:0]  iterations;

   // The controller sequences start, divide, update, square, residual and
   // test, and holds the result valid flag so a new item can be taken while
   // the previous result still waits at the output register.
   nsr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // The datapath holds the registers, the shared divider and the squarer.
   nsr_datapath #(
      .MAX_ITER      (MAX_ITER),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_value         (req_tdata[VALUE_W-1:0]),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .cmd               (cmd),
      .status            (status),
      .rsp_root          (root),
      .rsp_iterations    (iterations),
      .rsp_not_converged (rsp_tuser)
   );

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, iterations, root};

endmodule

[hw/rtl/nsr_datapath.sv]
// Datapath of the Newton square root block: registers, divider, squarer, residual.
`timescale 1ns / 1ps

module nsr_datapath #(
   parameter int MAX_ITER      = 32,
   parameter int FRACTION_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [nsr_pkg::VALUE_W-1:0]         req_value,
   input  logic                                csr_we,
   input  logic [nsr_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [nsr_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  nsr_pkg::dp_cmd_type                 cmd,
   output nsr_pkg::dp_status_type              status,
   output logic [nsr_pkg::VALUE_W-1:0]         rsp_root,
   output logic [nsr_pkg::ITER_W-1:0]          rsp_iterations,
   output logic                                rsp_not_converged
);
   import nsr_pkg::*;

   localparam int NUM_W = VALUE_W + FRACTION_BITS;
   localparam int CNT_W = $clog2(NUM_W);
   localparam int WIDE_W = 2 * VALUE_W;
   localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(NUM_W - 1);
   localparam logic [ITER_W-1:0] ITER_CAP = ITER_W'(MAX_ITER);

   logic [TOL_W-1:0]   tol_ff;
   logic               check_first_ff;
   logic [VALUE_W-1:0] value_ff;
   logic [VALUE_W-1:0] guess_ff;
   logic [ITER_W-1:0]  iter_ff;
   logic               nc_ff;
   logic [WIDE_W-1:0]  square_ff;
   logic [WIDE_W-1:0]  resid_ff;
   logic [VALUE_W-1:0] rem_ff;
   logic [NUM_W-1:0]   num_ff;
   logic [VALUE_W-1:0] divisor_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [VALUE_W-1:0] root_ff;
   logic [ITER_W-1:0]  iter_out_ff;
   logic               nc_out_ff;

   logic [WIDE_W-1:0]  sq_scaled;
   logic [WIDE_W-1:0]  value_wide;
   logic [WIDE_W-1:0]  resid_in;
   logic [VALUE_W:0]   trial;
   logic               fits;
   logic [VALUE_W-1:0] rem_in;
   logic [VALUE_W-1:0] quot_sat;
   logic [VALUE_W:0]   upd_sum;

   // Residual |value - guess^2 / 2^F|, taken from the registered square.
   assign sq_scaled  = square_ff >> FRACTION_BITS;
   assign value_wide = {{VALUE_W{1'b0}}, value_ff};
   assign resid_in   = (value_wide >= sq_scaled) ? (value_wide - sq_scaled)
                                                 : (sq_scaled - value_wide);

   // One restoring division step; quotient bits shift in behind the dividend.
   // The partial remainder always stays below the divisor, so 32 bits hold it.
   assign trial  = {rem_ff, num_ff[NUM_W-1]};
   assign fits   = (trial >= {1'b0, divisor_ff});
   assign rem_in = fits ? VALUE_W'(trial - {1'b0, divisor_ff}) : trial[VALUE_W-1:0];

   // Quotients beyond 32 bits saturate to all ones.
   assign quot_sat = (|num_ff[NUM_W-1:VALUE_W]) ? {VALUE_W{1'b1}} : num_ff[VALUE_W-1:0];
   assign upd_sum  = {1'b0, guess_ff} + {1'b0, quot_sat};

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff         <= TOLERANCE_RESET;
         check_first_ff <= CHECK_FIRST_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TOLERANCE:   tol_ff         <= csr_wdata[TOL_W-1:0];
            CSR_CHECK_FIRST: check_first_ff <= csr_wdata[0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iter_ff <= '0;
      end else if (cmd.load) begin
         iter_ff <= '0;
      end else if (cmd.update) begin
         iter_ff <= iter_ff + ITER_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         value_ff <= req_value;
         guess_ff <= req_value >> 1;
         nc_ff    <= 1'b0;
      end else begin
         if (cmd.update) begin
            guess_ff <= VALUE_W'(upd_sum >> 1);
         end
         if (cmd.set_nc) begin
            nc_ff <= 1'b1;
         end
      end
      if (cmd.square) begin
         square_ff <= guess_ff * guess_ff;
      end
      if (cmd.resid) begin
         resid_ff <= resid_in;
      end
      // A zero guess divides as one ulp.
      if (cmd.div_start) begin
         divisor_ff <= (guess_ff == '0) ? VALUE_W'(1) : guess_ff;
         num_ff     <= {value_ff, {FRACTION_BITS{1'b0}}};
         rem_ff     <= '0;
         cnt_ff     <= CNT_LAST;
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         num_ff <= {num_ff[NUM_W-2:0], fits};
         cnt_ff <= cnt_ff - CNT_W'(1);
      end
      if (cmd.out_load) begin
         root_ff     <= guess_ff;
         iter_out_ff <= iter_ff;
         nc_out_ff   <= nc_ff;
      end
   end

   always_comb begin
      status.value_zero  = (value_ff == '0);
      status.check_first = check_first_ff;
      status.converged   = (resid_ff < {{(WIDE_W - TOL_W){1'b0}}, tol_ff});
      status.at_cap      = (iter_ff >= ITER_CAP);
      status.div_last    = (cnt_ff == '0);
   end

   assign rsp_root          = root_ff;
   assign rsp_iterations    = iter_out_ff;
   assign rsp_not_converged = nc_out_ff;

   a_iter_bounded: assert property (@(posedge clock) disable iff (reset)
      iter_ff <= ITER_CAP)
      else $error("update count ran past the cap");

   a_nc_at_cap: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load && nc_ff) |-> (iter_ff == ITER_CAP))
      else $error("not-converged result without reaching the cap");

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> (divisor_ff != '0))
      else $error("divider started with a zero divisor");

endmodule

[hw/rtl/nsr_ctrl.sv]
// Controller state machine of the Newton square root block.
`timescale 1ns / 1ps

module nsr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  nsr_pkg::dp_status_type status,
   output nsr_pkg::dp_cmd_type    cmd
);
   import nsr_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_START;
            end
         end
         ST_START: begin
            priority if (status.value_zero) begin
               state_in = ST_FINISH;
            end else if (!status.check_first) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               state_in = ST_SQUARE;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_SQUARE;
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = ST_RESID;
         end
         ST_RESID: begin
            cmd.resid = 1'b1;
            state_in  = ST_CHECK;
         end
         ST_CHECK: begin
            priority if (status.converged) begin
               state_in = ST_FINISH;
            end else if (status.at_cap) begin
               cmd.set_nc = 1'b1;
               state_in   = ST_FINISH;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      priority if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten before it was taken");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_START))
      else $error("accepted item did not start a computation");

endmodule

[verif/square_root_checker.sv]
// Checker that predicts and compares every result of the Newton square root block.
`timescale 1ns / 1ps

module square_root_checker #(
   parameter int MAX_ITER      = nsr_pkg::DEFAULT_MAX_ITER,
   parameter int FRACTION_BITS = nsr_pkg::DEFAULT_FRACTION_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [nsr_pkg::REQ_TDATA_W-1:0] req_tdata,   // value[31:0]
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [nsr_pkg::RSP_TDATA_W-1:0] rsp_tdata,   // root[31:0], iterations[38:32], pad
   input  logic                            rsp_tuser,   // not_converged
   input  logic                            csr_we,
   input  logic [nsr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [nsr_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                              fail_count,
   output int                              pending_count,
   output int                              checked_count,
   output int                              capped_count
);

   import nsr_pkg::*;

   typedef struct packed {
      logic [VALUE_W-1:0] root;
      logic [ITER_W-1:0]  iterations;
      logic               not_converged;
   } root_result_type;

   root_result_type    expected_roots[$];
   logic [TOL_W-1:0]   tolerance_ff;
   logic               check_first_ff;

   // One Newton update: mean of the guess and value/guess, with a zero guess
   // used as one ulp and the quotient saturated to 32 bits.
   function automatic logic [63:0] newton_step(input logic [63:0] v, input logic [63:0] g);
      logic [63:0] divisor;
      logic [63:0] quotient;
      divisor  = (g == 64'd0) ? 64'd1 : g;
      quotient = (v << FRACTION_BITS) / divisor;
      if (quotient > 64'hFFFF_FFFF)
         quotient = 64'hFFFF_FFFF;
      return (g + quotient) >> 1;
   endfunction

   function automatic root_result_type newton_root(input logic [VALUE_W-1:0] value,
                                                   input logic [TOL_W-1:0] tol,
                                                   input logic test_first);
      logic [63:0]     v;
      logic [63:0]     g;
      logic [63:0]     square;
      logic [63:0]     residual;
      int              count;
      logic            capped;
      logic            done;
      root_result_type r;
      v      = 64'(value);
      g      = v >> 1;
      count  = 0;
      capped = 1'b0;
      done   = (value == '0);
      if (!done && !test_first) begin
         g     = newton_step(v, g);
         count = 1;
      end
      while (!done) begin
         square   = (g * g) >> FRACTION_BITS;
         residual = (v >= square) ? v - square : square - v;
         if (residual < 64'(tol)) begin
            done = 1'b1;
         end else if (count >= MAX_ITER) begin
            capped = 1'b1;
            done   = 1'b1;
         end else begin
            g     = newton_step(v, g);
            count = count + 1;
         end
      end
      r.root          = g[VALUE_W-1:0];
      r.iterations    = ITER_W'(count);
      r.not_converged = capped;
      return r;
   endfunction

   always @(posedge clock) begin : watch
      root_result_type want;
      root_result_type got;
      int              errors;
      errors = 0;
      if (reset) begin
         tolerance_ff   <= TOLERANCE_RESET;
         check_first_ff <= CHECK_FIRST_RESET;
         expected_roots.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.root          = rsp_tdata[VALUE_W-1:0];
            got.iterations    = rsp_tdata[VALUE_W+ITER_W-1:VALUE_W];
            got.not_converged = rsp_tuser;
            if (expected_roots.size() == 0) begin
               $error("result item with nothing pending: root=%h iterations=%0d",
                      got.root, got.iterations);
               errors = errors + 1;
            end else begin
               want = expected_roots.pop_front();
               if (got.root !== want.root) begin
                  $error("root: expected %h, actual %h", want.root, got.root);
                  errors = errors + 1;
               end
               if (got.iterations !== want.iterations) begin
                  $error("iterations: expected %0d, actual %0d", want.iterations,
                         got.iterations);
                  errors = errors + 1;
               end
               if (got.not_converged !== want.not_converged) begin
                  $error("not_converged: expected %b, actual %b", want.not_converged,
                         got.not_converged);
                  errors = errors + 1;
               end
               checked_count <= checked_count + 1;
               capped_count  <= capped_count + int'(want.not_converged);
            end
         end
         if (req_tvalid && req_tready)
            expected_roots.push_back(newton_root(req_tdata[VALUE_W-1:0], tolerance_ff,
                                                 check_first_ff));
         if (csr_we) begin
            case (csr_index)
               CSR_TOLERANCE:   tolerance_ff   <= csr_wdata[TOL_W-1:0];
               CSR_CHECK_FIRST: check_first_ff <= csr_wdata[0];
            endcase
         end
      end
      fail_count    <= fail_count + errors;
      pending_count <= expected_roots.size();
   end

endmodule

[verif/newton_square_root_test.sv]
// Top of the Newton square root testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module newton_square_root_test;

   import nsr_pkg::*;

   localparam int MAX_ITER      = DEFAULT_MAX_ITER;
   localparam int FRACTION_BITS = DEFAULT_FRACTION_BITS;

   // The random part runs in phases, each with its own register setting.
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_ITEMS   = 120;
   localparam int CORNER_ITEMS  = 21;

   // Worst case for one item: every update taken, plus margin for the random
   // gaps on both channels. The limit allows several times that for every item.
   localparam int     ITEM_CYCLES = 5 + MAX_ITER * (FRACTION_BITS + 36) + 64;
   localparam longint CYCLE_LIMIT =
      4 * longint'(RANDOM_PHASES * PHASE_ITEMS + CORNER_ITEMS + 100) * ITEM_CYCLES;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;     // value[31:0]
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;           // root[31:0], iterations[38:32], zero pad
   logic                   rsp_tuser;           // not_converged
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   // While calm is set neither side inserts gaps.
   logic   calm     = 1'b0;
   longint cycles   = 0;
   int     items_sent = 0;
   int     settings_used = 1;

   int fail_count;
   int pending_count;
   int checked_count;
   int capped_count;

   always #5 clock = ~clock;

   newton_square_root #(
      .MAX_ITER      (MAX_ITER),
      .FRACTION_BITS (FRACTION_BITS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   square_root_checker #(
      .MAX_ITER      (MAX_ITER),
      .FRACTION_BITS (FRACTION_BITS)
   ) i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count),
      .capped_count  (capped_count)
   );

   // The receiver stalls with a chance of roughly 27 in a hundred unless calm is set.
   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= 27);
   end

   // Watchdog: a hung handshake or a lost result ends the run here.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $error("run did not finish within %0d cycles, %0d results outstanding",
                CYCLE_LIMIT, pending_count);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Directed operands. The first block runs with the registers as reset
   // leaves them (tolerance 1, residual tested first), the later blocks with
   // the extreme settings applied in the stimulus below.
   function automatic logic [VALUE_W-1:0] corner_value(input int n);
      case (n)
         0:       return 32'h0000_0000;   // zero operand returns at once
         1:       return 32'h0000_0001;   // one ulp, the start guess rounds to zero
         2:       return 32'h0000_0002;
         3:       return 32'h0000_0003;
         4:       return 32'h0001_0000;   // 1.0
         5:       return 32'h0004_0000;   // 4.0, an exact square
         6:       return 32'h8000_0000;
         7:       return 32'hFFFF_FFFF;   // largest operand
         8:       return 32'h7FFF_FFFF;
         9:       return 32'hAAAA_AAAA;
         10:      return 32'h5555_5555;
         11:      return 32'h0000_0001;   // zero tolerance from here: every update taken
         12:      return 32'h0000_0000;
         13:      return 32'hFFFF_FFFF;
         14:      return 32'h0001_0000;
         15:      return 32'h0001_0000;   // widest tolerance, one update before the test
         16:      return 32'h0000_0000;
         17:      return 32'hFFFF_FFFF;
         18:      return 32'h0001_0000;   // widest tolerance, tested first: no update
         19:      return 32'h0000_0003;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   // Random operands: uniform 32-bit words in half of the draws, so that every bit toggles,
   // mixed with tiny values, powers of two, exact squares and values near the top.
   function automatic logic [VALUE_W-1:0] random_value();
      int k;
      k = $urandom_range(1, 255);
      case ($urandom_range(9))
         0:       return VALUE_W'($urandom_range(1, 255));
         1:       return VALUE_W'(1) << $urandom_range(VALUE_W - 1);
         2:       return VALUE_W'(k * k) << FRACTION_BITS;
         3:       return 32'hFFFF_FFFF - VALUE_W'($urandom_range(255));
         4:       return ($urandom_range(3) == 0) ? '0 : VALUE_W'($urandom_range(1, 4095));
         default: return VALUE_W'($urandom());
      endcase
   endfunction

   // Offers one operand and returns once the block has taken it. The valid
   // line stays high from one item to the next unless a gap is inserted.
   task automatic send_value(input logic [VALUE_W-1:0] value);
      if (!calm) begin
         while ($urandom_range(99) < 27) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      items_sent = items_sent + 1;
   endtask

   // Stops offering items and waits until every pending result has been
   // checked. The first edge lets the checker count the last accepted item.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Registers are only written with the block idle. The upper bits of the
   // check_first write are random, since only bit 0 is kept.
   task automatic apply_settings(input logic [TOL_W-1:0] tol, input logic test_first);
      drain();
      csr_we    <= 1'b1;
      csr_index <= CSR_TOLERANCE;
      csr_wdata <= CSR_DATA_W'(tol);
      @(posedge clock);
      csr_index <= CSR_CHECK_FIRST;
      csr_wdata <= {15'($urandom()), test_first};
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      settings_used = settings_used + 1;
   endtask

   initial begin : stimulus
      logic [TOL_W-1:0] tol;
      logic             test_first;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: reset settings first, then the extremes.
      for (int n = 0; n < CORNER_ITEMS; n++) begin
         if (n == 11)
            apply_settings('0, 1'b0);
         else if (n == 15)
            apply_settings('1, 1'b0);
         else if (n == 18)
            apply_settings('1, 1'b1);
         send_value(corner_value(n));
      end

      // Random part. Phase 0 uses zero tolerance and phase 1 the widest one;
      // a quarter of the others use a tight tolerance that large operands
      // seldom meet, so the update cap is reached often.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         test_first = 1'($urandom_range(1));
         case (p)
            0:       tol = '0;
            1:       tol = '1;
            default: tol = ($urandom_range(3) == 0) ? TOL_W'($urandom_range(1, 16))
                                                    : TOL_W'($urandom_range(65535));
         endcase
         // Phase 5 runs with no gaps on either side.
         calm <= (p == 5);
         apply_settings(tol, test_first);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // Once, the sender holds back in mid-phase until every result is in.
            if (p == 3 && i == PHASE_ITEMS / 2)
               drain();
            send_value(random_value());
         end
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);

      $display("Sent %0d operands under %0d register settings; %0d roots compared.",
               items_sent, settings_used, checked_count);
      $display("%0d roots stopped at the update cap of %0d; %0d mismatches.",
               capped_count, MAX_ITER, fail_count);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/nsr_pkg.sv
hw/rtl/nsr_datapath.sv
hw/rtl/nsr_ctrl.sv
hw/rtl/newton_square_root.sv
verif/square_root_checker.sv
verif/newton_square_root_test.sv
